[rtl/qsp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types for the queued sample player.
package qsp_pkg;

	localparam int QUEUE_DEPTH   = 8;
	localparam int FRACTION_BITS = 16;

	localparam int ADDR_W     = 24;
	localparam int LEN_W      = 24;
	localparam int STEP_W     = 24;
	localparam int RADDR_W    = 25;
	localparam int IDX_IN_W   = 4;
	localparam int CNT_PORT_W = 4;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SEL_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CMP_W = ((CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W) + 1;
	localparam int ACC_W = ((FRACTION_BITS > STEP_W) ? FRACTION_BITS : STEP_W) + 1;

	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_TICK   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [STEP_W-1:0] step;
	} seg_t;

	typedef struct packed {
		logic start;  // checked start, index in range
		logic tick;
	} play_cmd_t;

endpackage

[rtl/qsp_seg_queue.sv]
`timescale 1ns / 1ps
// Segment queue: descriptor table and fill count.
module qsp_seg_queue import qsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  seg_t             wr_seg,
	input  logic [CMP_W-1:0] rd_sel,
	output seg_t             rd_seg,
	output logic             full,
	output logic [CNT_W-1:0] count,
	output logic [CNT_W-1:0] count_nxt
);

	seg_t             tab_q [QUEUE_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic             wr_ok;

	assign count     = count_q;
	assign full      = (count_q >= CNT_W'(QUEUE_DEPTH));
	assign wr_ok     = wr_en && !full;
	assign count_nxt = count_q + CNT_W'(wr_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// entries never written read as don't-care; only indices below the count are used
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			tab_q[count_q[SEL_W-1:0]] <= wr_seg;
		end
	end

	always_comb begin
		if (rd_sel < CMP_W'(QUEUE_DEPTH)) begin
			rd_seg = tab_q[rd_sel[SEL_W-1:0]];
		end else begin
			rd_seg = '0;
		end
	end

endmodule

[rtl/qsp_playback.sv]
`timescale 1ns / 1ps
// Playback state and phase accumulator.
module qsp_playback import qsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  play_cmd_t          cmd,
	input  logic [CMP_W-1:0]   start_sel,
	input  logic [CNT_W-1:0]   count,
	input  seg_t               rd_seg,
	output logic [CMP_W-1:0]   rd_sel,
	output logic [RADDR_W-1:0] read_address,
	output logic               sample_valid,
	output logic               running_nxt
);

	logic [CNT_W-1:0]         cur_q;
	logic [ADDR_W-1:0]        base_q;
	logic [LEN_W-1:0]         len_q;
	logic [STEP_W-1:0]        step_q;
	logic [RADDR_W-1:0]       idx_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic                     run_q;

	logic [CNT_W-1:0]         cur_d;
	logic [ADDR_W-1:0]        base_d;
	logic [LEN_W-1:0]         len_d;
	logic [STEP_W-1:0]        step_d;
	logic [RADDR_W-1:0]       idx_d;
	logic [FRACTION_BITS-1:0] frac_d;
	logic                     run_d;

	logic [CMP_W-1:0] nxt_sel;
	logic             have_nxt;
	logic             at_end;
	logic [ACC_W-1:0] acc;

	assign nxt_sel  = CMP_W'(cur_q) + CMP_W'(1);
	assign have_nxt = (nxt_sel < CMP_W'(count));
	assign at_end   = (idx_q >= RADDR_W'(len_q));
	assign rd_sel   = cmd.start ? start_sel : nxt_sel;

	always_comb begin
		cur_d        = cur_q;
		base_d       = base_q;
		len_d        = len_q;
		step_d       = step_q;
		idx_d        = idx_q;
		frac_d       = frac_q;
		run_d        = run_q;
		acc          = '0;
		sample_valid = 1'b0;
		read_address = '0;
		if (cmd.start) begin
			cur_d  = start_sel[CNT_W-1:0];
			base_d = rd_seg.addr;
			len_d  = rd_seg.len;
			step_d = rd_seg.step;
			idx_d  = '0;
			frac_d = '0;
			run_d  = 1'b1;
		end else if (cmd.tick && run_q) begin
			if (at_end) begin
				if (!have_nxt) begin
					run_d = 1'b0;
				end else begin
					cur_d  = nxt_sel[CNT_W-1:0];
					base_d = rd_seg.addr;
					len_d  = rd_seg.len;
					step_d = rd_seg.step;
					idx_d  = '0;
					frac_d = '0;
				end
			end
			// empty freshly loaded segment gives one silent tick
			if (run_d && (idx_d < RADDR_W'(len_d))) begin
				sample_valid = 1'b1;
				read_address = RADDR_W'(base_d) + idx_d;
				acc          = ACC_W'(frac_d) + ACC_W'(step_d);
				idx_d        = idx_d + RADDR_W'(acc >> FRACTION_BITS);
				frac_d       = acc[FRACTION_BITS-1:0];
			end
		end
	end

	assign running_nxt = run_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			base_q <= '0;
			len_q  <= '0;
			step_q <= '0;
			idx_q  <= '0;
			frac_q <= '0;
			run_q  <= 1'b0;
		end else begin
			cur_q  <= cur_d;
			base_q <= base_d;
			len_q  <= len_d;
			step_q <= step_d;
			idx_q  <= idx_d;
			frac_q <= frac_d;
			run_q  <= run_d;
		end
	end

endmodule

[rtl/queued_sample_player.sv]
`timescale 1ns / 1ps
// Queued sample player top level: input register, queue, playback, result register.
//
// Usage
//   A transaction is accepted on a rising edge with start high and busy low.
//   func selects the operation: append a segment (seg_address, seg_length,
//   seg_step), start playing the queued segment at start_index, or tick.
//   Every accepted transaction yields exactly one result, shown for one
//   cycle with done high: read_address/sample_valid for a tick, status for
//   append and start, and playing/queue_count as they stand afterwards.
// Pipeline and throughput
//   The transaction lands in the input register at the accepting edge,
//   and the next edge updates the state and loads the result register.
//   One transaction per cycle is sustained; busy is never raised, since each
//   transaction is finished by one pass through the queue read mux, the end
//   of segment compare and the phase accumulator add.
// Reset
//   arst_n clears the queue count, the playback state (stopped) and the
//   strobes at once. Queue entries are not cleared; only entries below the
//   count are ever read.
// Back-pressure
//   None: the receiver must take every result in the cycle done is high.
module queued_sample_player import qsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            func,
	input  logic [ADDR_W-1:0]     seg_address,
	input  logic [LEN_W-1:0]      seg_length,
	input  logic [STEP_W-1:0]     seg_step,
	input  logic [IDX_IN_W-1:0]   start_index,
	output logic                  done,
	output logic [RADDR_W-1:0]    read_address,
	output logic                  sample_valid,
	output logic                  playing,
	output logic [1:0]            status,
	output logic [CNT_PORT_W-1:0] queue_count
);

	// input register
	logic                vld_s1;
	func_t               func_s1;
	seg_t                seg_s1;
	logic [IDX_IN_W-1:0] sidx_s1;

	// result register
	logic                  done_s2;
	logic [RADDR_W-1:0]    raddr_s2;
	logic                  svalid_s2;
	logic                  playing_s2;
	status_t               status_s2;
	logic [CNT_PORT_W-1:0] qcount_s2;

	logic                  accept;
	logic                  is_append;
	logic                  is_start;
	logic                  start_ok;
	logic [CMP_W-1:0]      start_sel;
	play_cmd_t             cmd;
	logic [CMP_W-1:0]      rd_sel;
	seg_t                  rd_seg;
	logic                  q_full;
	logic [CNT_W-1:0]      q_count;
	logic [CNT_W-1:0]      q_count_nxt;
	logic [RADDR_W-1:0]    pb_raddr;
	logic                  pb_svalid;
	logic                  pb_running;
	status_t               status_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func_t'(func);
			seg_s1.addr <= seg_address;
			seg_s1.len  <= seg_length;
			seg_s1.step <= seg_step;
			sidx_s1     <= start_index;
		end
	end

	// decode; an unused func code falls through with no effect
	assign is_append = vld_s1 && (func_s1 == FUNC_APPEND);
	assign is_start  = vld_s1 && (func_s1 == FUNC_START);
	assign start_sel = CMP_W'(sidx_s1);
	assign start_ok  = (start_sel < CMP_W'(q_count));
	assign cmd.start = is_start && start_ok;
	assign cmd.tick  = vld_s1 && (func_s1 == FUNC_TICK);

	qsp_seg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (is_append),
		.wr_seg    (seg_s1),
		.rd_sel    (rd_sel),
		.rd_seg    (rd_seg),
		.full      (q_full),
		.count     (q_count),
		.count_nxt (q_count_nxt)
	);

	qsp_playback u_playback (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.start_sel    (start_sel),
		.count        (q_count),
		.rd_seg       (rd_seg),
		.rd_sel       (rd_sel),
		.read_address (pb_raddr),
		.sample_valid (pb_svalid),
		.running_nxt  (pb_running)
	);

	always_comb begin
		status_d = ST_OK;
		if (is_append && q_full) begin
			status_d = ST_FULL;
		end else if (is_start && !start_ok) begin
			status_d = ST_BAD_INDEX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			raddr_s2   <= pb_raddr;
			svalid_s2  <= pb_svalid;
			playing_s2 <= pb_running;
			status_s2  <= status_d;
			qcount_s2  <= CNT_PORT_W'(q_count_nxt);
		end
	end

	assign done         = done_s2;
	assign read_address = raddr_s2;
	assign sample_valid = svalid_s2;
	assign playing      = playing_s2;
	assign status       = status_s2;
	assign queue_count  = qcount_s2;

endmodule

[tb/queued_sample_player_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the queued sample player against a predictor.
module queued_sample_player_test;
	import qsp_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 9;
	// Slowest correct run is roughly 1600 transactions with their idle gaps, plus drains.
	localparam int CYCLE_LIMIT   = 200000;
	// Input register plus result register, with a little margin.
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_LIMIT  = 10;

	// One result as it appears on the result ports.
	typedef struct packed {
		logic [RADDR_W-1:0]    read_address;
		logic                  sample_valid;
		logic                  playing;
		status_t               status;
		logic [CNT_PORT_W-1:0] queue_count;
	} player_result_t;

	// Stimulus side; every input known from time zero.
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  start        = 1'b0;
	func_t                 func         = FUNC_NONE;
	logic [ADDR_W-1:0]     seg_address  = '0;
	logic [LEN_W-1:0]      seg_length   = '0;
	logic [STEP_W-1:0]     seg_step     = '0;
	logic [IDX_IN_W-1:0]   start_index  = '0;

	// Result side.
	logic                  busy;
	logic                  done;
	logic [RADDR_W-1:0]    read_address;
	logic                  sample_valid;
	logic                  playing;
	logic [1:0]            status;
	logic [CNT_PORT_W-1:0] queue_count;

	// Predicted player state: segment queue and playback position.
	logic [ADDR_W-1:0]        seg_base_q [QUEUE_DEPTH];
	logic [LEN_W-1:0]         seg_len_q  [QUEUE_DEPTH];
	logic [STEP_W-1:0]        seg_step_q [QUEUE_DEPTH];
	int unsigned              queued_segs = 0;
	int unsigned              play_seg    = 0;
	logic [ADDR_W-1:0]        play_base   = '0;
	logic [LEN_W-1:0]         play_len    = '0;
	logic [STEP_W-1:0]        play_step   = '0;
	logic [RADDR_W-1:0]       play_pos    = '0;
	logic [FRACTION_BITS-1:0] play_frac   = '0;
	bit                       play_on     = 1'b0;

	// Results still owed by the block, oldest first.
	player_result_t expected_results[$];

	int unsigned mismatches      = 0;
	int unsigned results_checked = 0;
	int unsigned items_sent      = 0;
	int unsigned sample_reads    = 0;
	int unsigned playback_stops  = 0;
	int unsigned full_appends    = 0;
	int unsigned rejected_starts = 0;
	int unsigned cycle_count     = 0;

	queued_sample_player dut (.*);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Select a queued segment and clear the phase accumulator.
	function automatic void load_playback(input int unsigned idx);
		play_seg  = idx;
		play_base = seg_base_q[idx];
		play_len  = seg_len_q[idx];
		play_step = seg_step_q[idx];
		play_pos  = '0;
		play_frac = '0;
	endfunction

	// Advance the predicted state by one transaction and return its result.
	function automatic player_result_t predict_player(input func_t op,
			input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
			input logic [STEP_W-1:0] step, input logic [IDX_IN_W-1:0] idx);
		player_result_t   r;
		logic [ACC_W-1:0] acc;
		bit               go;
		r.read_address = '0;
		r.sample_valid = 1'b0;
		r.status       = ST_OK;
		case (op)
			FUNC_APPEND: begin
				if (queued_segs >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
					full_appends++;
				end else begin
					seg_base_q[queued_segs] = addr;
					seg_len_q[queued_segs]  = len;
					seg_step_q[queued_segs] = step;
					queued_segs++;
				end
			end
			FUNC_START: begin
				// a refused start leaves playback exactly as it was
				if (idx >= queued_segs) begin
					r.status = ST_BAD_INDEX;
					rejected_starts++;
				end else begin
					load_playback(idx);
					play_on = 1'b1;
				end
			end
			FUNC_TICK: begin
				if (play_on) begin
					go = 1'b1;
					// end of segment: move on, or stop after the last one
					if (play_pos >= play_len) begin
						if (play_seg + 1 >= queued_segs) begin
							play_on = 1'b0;
							go      = 1'b0;
							playback_stops++;
						end else begin
							load_playback(play_seg + 1);
						end
					end
					// an empty segment gives a silent tick but keeps running
					if (go && play_pos < play_len) begin
						r.read_address = RADDR_W'(play_base) + play_pos;
						r.sample_valid = 1'b1;
						acc            = ACC_W'(play_frac) + ACC_W'(play_step);
						play_pos       = play_pos + RADDR_W'(acc >> FRACTION_BITS);
						play_frac      = acc[FRACTION_BITS-1:0];
						sample_reads++;
					end
				end
			end
			default: ;
		endcase
		r.playing     = play_on;
		r.queue_count = CNT_PORT_W'(queued_segs);
		return r;
	endfunction

	// Offer one transaction and hold it until the block takes it.
	task automatic send_item(input func_t op, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] len, input logic [STEP_W-1:0] step,
			input logic [IDX_IN_W-1:0] idx);
		start       <= 1'b1;
		func        <= op;
		seg_address <= addr;
		seg_length  <= len;
		seg_step    <= step;
		start_index <= idx;
		do @(posedge clk); while (busy);
		expected_results.push_back(predict_player(op, addr, len, step, idx));
		items_sent++;
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Sender holds off until every outstanding result has come back.
	task automatic drain_results();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Random mix: mostly ticks, with starts, refused appends and the unused code.
	task automatic run_random_items(input int count, input int idle_pct);
		int unsigned         pick;
		func_t               op;
		logic [IDX_IN_W-1:0] idx;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			idx  = IDX_IN_W'($urandom);
			if (pick < 5) begin
				op = FUNC_START;
				// mostly a valid index, sometimes anything at all
				if (queued_segs > 0 && $urandom_range(9) < 8)
					idx = IDX_IN_W'($urandom_range(queued_segs - 1, 0));
			end else if (pick < 8) begin
				op = FUNC_APPEND;
			end else if (pick < 10) begin
				op = FUNC_NONE;
			end else begin
				op = FUNC_TICK;
			end
			send_item(op, ADDR_W'($urandom), LEN_W'($urandom), STEP_W'($urandom), idx);
			if (idle_pct > 0 && $urandom_range(99) < idle_pct)
				idle_cycles(int'($urandom_range(4, 1)));
		end
	endtask

	task automatic test_directed_cases();
		send_item(FUNC_TICK, '0, '0, '0, '0);                        // tick while stopped
		send_item(FUNC_START, '1, '1, '1, '0);                       // start on an empty queue
		send_item(FUNC_APPEND, 24'hFFFFFF, 24'd3, 24'h010000, '1);  // addresses cross 2^24
		send_item(FUNC_APPEND, '0, '0, 24'h008000, '0);              // empty segment
		send_item(FUNC_APPEND, 24'h123456, 24'd4, 24'h018000, '0);  // step of one and a half
		send_item(FUNC_START, '0, '0, '0, 4'd0);
		// three samples, silent tick, three samples, stop, tick while stopped
		repeat (9) send_item(FUNC_TICK, '0, '0, '0, '0);
		send_item(FUNC_START, '0, '0, '0, 4'd3);                     // index equal to count
		send_item(FUNC_START, '0, '0, '0, 4'hF);                     // largest index
		send_item(FUNC_APPEND, '0, 24'hFFFFFF, 24'hFFFFFF, '0);      // largest length and step
		send_item(FUNC_APPEND, 24'h000100, 24'd5, '0, '0);           // zero step never advances
		send_item(FUNC_START, '0, '0, '0, 4'd3);
		send_item(FUNC_TICK, '1, '1, '1, '1);
		send_item(FUNC_START, '0, '0, '0, 4'd9);                     // refused while running
		send_item(FUNC_TICK, '0, '0, '0, '0);
		send_item(FUNC_NONE, '1, '1, '1, '1);                        // unused code
		for (int k = 0; k < 3; k++)
			send_item(FUNC_APPEND, ADDR_W'($urandom), LEN_W'($urandom_range(24, 0)),
				STEP_W'($urandom_range(24'h030000, 24'h004000)), '0);
		send_item(FUNC_APPEND, '1, '1, '1, '1);                      // queue now full
	endtask

	// Pause after three ticks of a started segment until the pipeline is empty, then carry on.
	task automatic test_drain_mid_playback();
		send_item(FUNC_START, '0, '0, '0, 4'd5);
		repeat (3) send_item(FUNC_TICK, ADDR_W'($urandom), LEN_W'($urandom),
			STEP_W'($urandom), IDX_IN_W'($urandom));
		drain_results();
		repeat (3) send_item(FUNC_TICK, ADDR_W'($urandom), LEN_W'($urandom),
			STEP_W'($urandom), IDX_IN_W'($urandom));
	endtask

	task automatic test_back_to_back();
		run_random_items(500, 0);
	endtask

	task automatic test_sparse_sender();
		run_random_items(500, 75);
	endtask

	task automatic test_occasional_gaps();
		run_random_items(500, 19);
	endtask

	// Result checker: one result per cycle with done high, compared with the oldest prediction.
	always @(posedge clk) begin
		player_result_t want;
		if (arst_n && done) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result addr %h valid %b play %b st %0d cnt %0d",
						$realtime, read_address, sample_valid, playing, status, queue_count);
			end else begin
				want = expected_results.pop_front();
				if (read_address !== want.read_address || sample_valid !== want.sample_valid ||
						playing !== want.playing || status !== want.status ||
						queue_count !== want.queue_count) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: result %0d expected addr %h valid %b play %b st %0d cnt %0d",
							$realtime, results_checked, want.read_address,
							want.sample_valid, want.playing, want.status, want.queue_count);
						$display("%0t: result %0d got      addr %h valid %b play %b st %0d cnt %0d",
							$realtime, results_checked, read_address, sample_valid,
							playing, status, queue_count);
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding",
			cycle_count, expected_results.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_drain_mid_playback();
		drain_results();
		test_back_to_back();
		drain_results();
		test_sparse_sender();
		drain_results();
		test_occasional_gaps();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d transactions, %0d results, %0d sample reads, %0d stops.",
			items_sent, results_checked, sample_reads, playback_stops);
		$display("Refused %0d appends on a full queue and %0d starts with a bad index.",
			full_appends, rejected_starts);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/qsp_pkg.sv
rtl/qsp_seg_queue.sv
rtl/qsp_playback.sv
rtl/queued_sample_player.sv
tb/queued_sample_player_test.sv
